// ----- hw/rtl/windkessel_rcr_pressure_step_macros.svh -----
// ---------------------------------------------------------------------------
// Windkessel pressure step: assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef WINDKESSEL_RCR_PRESSURE_STEP_MACROS_SVH
`define WINDKESSEL_RCR_PRESSURE_STEP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WKP_ASSERT_SAME(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WKP_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/wkp_pkg.sv -----
// ---------------------------------------------------------------------------
// wkp_pkg
// Types, widths, register indexes and saturation helpers shared by the
// windkessel pressure step block.
// ---------------------------------------------------------------------------
package wkp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_W     = 32;

    // Capacitor pressure width, capped so that it fits a 64-bit signed value.
    localparam int PC_W      = (VALUE_WIDTH + FRAC_BITS > 63) ? 63 : VALUE_WIDTH + FRAC_BITS;
    localparam int OUT_SAT_W = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
    localparam int QRP_W     = 2 * FIELD_W - FRAC_BITS + 1;
    localparam int WIDE_W    = 66;
    localparam int PROD_W    = 2 * FIELD_W;
    localparam int ACC_W     = 4 * FIELD_W;
    localparam int MAG_W     = 3 * FIELD_W;
    localparam int DEN_W     = PROD_W + 1;
    localparam int QUO_W     = PC_W - 1;
    localparam int CNT_W     = $clog2(QUO_W);

    localparam logic signed [WIDE_W-1:0] PC_MAX_WIDE =
        {{(WIDE_W - PC_W + 1){1'b0}}, {(PC_W - 1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] PC_MIN_WIDE = ~PC_MAX_WIDE;
    localparam logic signed [WIDE_W-1:0] OUT_MAX_WIDE =
        {{(WIDE_W - OUT_SAT_W + 1){1'b0}}, {(OUT_SAT_W - 1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] OUT_MIN_WIDE = ~OUT_MAX_WIDE;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROXIMAL_RESISTANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITANCE         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISTAL_RESISTANCE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLOW_RATE           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_PRESSURE    = 3'd4;

    localparam logic [FIELD_W-1:0] ONE_FIXED = FIELD_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic [FIELD_W-1:0] sample_time;
        logic               first_sample;
    } in_word_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] pressure;
        logic                      time_not_advanced;
    } out_word_t;

    typedef struct packed {
        logic [FIELD_W-1:0]        proximal_resistance;
        logic [FIELD_W-1:0]        capacitance;
        logic [FIELD_W-1:0]        distal_resistance;
        logic signed [FIELD_W-1:0] flow_rate;
        logic signed [FIELD_W-1:0] initial_pressure;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_QRP   = 3'd0,
        MUL_PC_LO = 3'd1,
        MUL_PC_HI = 3'd2,
        MUL_QDT   = 3'd3,
        MUL_RDC   = 3'd4,
        MUL_M0    = 3'd5,
        MUL_M1    = 3'd6,
        MUL_M2    = 3'd7
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } acc_op_t;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_32 = 2'd1,
        SH_64 = 2'd2
    } acc_shift_t;

    typedef enum logic [1:0] {
        SIGN_POS = 2'd0,
        SIGN_PC  = 2'd1,
        SIGN_Q   = 2'd2
    } sign_sel_t;

    typedef enum logic [1:0] {
        RES_NONE   = 2'd0,
        RES_INIT   = 2'd1,
        RES_HELD   = 2'd2,
        RES_REPORT = 2'd3
    } res_op_t;

    typedef struct packed {
        logic       latch_in;
        mul_sel_t   mul_sel;
        acc_op_t    acc_op;
        acc_shift_t acc_shift;
        sign_sel_t  sign_sel;
        logic       qrp_load;
        logic       den_load;
        logic       div_init;
        logic       div_step;
        logic       pc_load;
        res_op_t    res_op;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic first_eff;
        logic advanced;
        logic out_free;
    } status_t;

    function automatic logic signed [PC_W-1:0] sat_pc(input logic signed [WIDE_W-1:0] v);
        logic signed [PC_W-1:0] r;
        if (v > PC_MAX_WIDE)
            r = PC_W'(PC_MAX_WIDE);
        else if (v < PC_MIN_WIDE)
            r = PC_W'(PC_MIN_WIDE);
        else
            r = PC_W'(v);
        return r;
    endfunction

    function automatic logic signed [FIELD_W-1:0] sat_out(input logic signed [WIDE_W-1:0] v);
        logic signed [FIELD_W-1:0] r;
        if (v > OUT_MAX_WIDE)
            r = FIELD_W'(OUT_MAX_WIDE);
        else if (v < OUT_MIN_WIDE)
            r = FIELD_W'(OUT_MIN_WIDE);
        else
            r = FIELD_W'(v);
        return r;
    endfunction

endpackage

// ----- hw/rtl/wkp_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// wkp_cfg_regs
// Configuration register file: resistances, compliance, flow and the
// starting pressure, written through a plain indexed write port.
// ---------------------------------------------------------------------------
module wkp_cfg_regs
    import wkp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PROXIMAL_RESISTANCE: cfg_next.proximal_resistance = cfg_data;
                REG_CAPACITANCE:         cfg_next.capacitance         = cfg_data;
                REG_DISTAL_RESISTANCE:   cfg_next.distal_resistance   = cfg_data;
                REG_FLOW_RATE:           cfg_next.flow_rate           = signed'(cfg_data);
                REG_INITIAL_PRESSURE:    cfg_next.initial_pressure    = signed'(cfg_data);
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.proximal_resistance <= ONE_FIXED;
            cfg_reg.capacitance         <= ONE_FIXED;
            cfg_reg.distal_resistance   <= ONE_FIXED;
            cfg_reg.flow_rate           <= '0;
            cfg_reg.initial_pressure    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/wkp_datapath.sv -----
// ---------------------------------------------------------------------------
// wkp_datapath
// Shared 32x32 multiplier with a 128-bit accumulator, a one-bit-per-cycle
// restoring divider, the model state and the output word register.
// ---------------------------------------------------------------------------
module wkp_datapath
    import wkp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    output status_t   status,
    input  cfg_t      cfg,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    // Control state
    logic signed [PC_W-1:0] pc_reg, pc_next;
    logic [FIELD_W-1:0]     prev_time_reg, prev_time_next;
    logic                   started_reg, started_next;
    logic                   out_valid_reg, out_valid_next;

    // Working registers
    logic [FIELD_W-1:0]      time_reg;
    logic                    first_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic signed [QRP_W-1:0] qrp_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [QUO_W-1:0]        quo_reg, quo_next;
    logic                    ovf_reg;
    logic signed [FIELD_W-1:0] res_pressure_reg, res_pressure_next;
    logic                    res_held_reg, res_held_next;
    out_word_t               out_data_reg;

    logic [FIELD_W-1:0]      dt;
    logic [FIELD_W-1:0]      q_mag;
    logic                    q_neg;
    logic signed [63:0]      pc_wide;
    logic [63:0]             pc_mag;
    logic [FIELD_W-1:0]      mul_a, mul_b;
    logic [ACC_W-1:0]        term;
    logic                    term_neg;
    logic [ACC_W-1:0]        acc_abs;
    logic [PROD_W-1:0]       prod_sh;
    logic signed [QRP_W-1:0] qrp_pos;
    logic signed [WIDE_W-1:0] init_diff, rep_sum;
    logic [ACC_W-1:0]        den_sh;
    logic [DEN_W:0]          trial, trial_diff;
    logic                    trial_ge;
    logic signed [PC_W-1:0]  pc_quo;

    assign dt      = time_reg - prev_time_reg;
    assign q_neg   = cfg.flow_rate[FIELD_W-1];
    assign q_mag   = q_neg ? FIELD_W'(-cfg.flow_rate) : FIELD_W'(cfg.flow_rate);
    assign pc_wide = 64'(pc_reg);
    assign pc_mag  = pc_reg[PC_W-1] ? 64'(-pc_wide) : 64'(pc_wide);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_QRP:   begin mul_a = q_mag;               mul_b = cfg.proximal_resistance; end
            MUL_PC_LO: begin mul_a = pc_mag[31:0];        mul_b = cfg.capacitance;         end
            MUL_PC_HI: begin mul_a = pc_mag[63:32];       mul_b = cfg.capacitance;         end
            MUL_QDT:   begin mul_a = q_mag;               mul_b = dt;                      end
            MUL_RDC:   begin mul_a = cfg.distal_resistance; mul_b = cfg.capacitance;       end
            MUL_M0:    begin mul_a = mag_reg[31:0];       mul_b = cfg.distal_resistance;   end
            MUL_M1:    begin mul_a = mag_reg[63:32];      mul_b = cfg.distal_resistance;   end
            MUL_M2:    begin mul_a = mag_reg[95:64];      mul_b = cfg.distal_resistance;   end
            default:   begin mul_a = '0;                  mul_b = '0;                      end
        endcase
    end

    // The accumulator adds the product registered in the previous cycle.
    always_comb
    begin
        case (cmd.acc_shift)
            SH_0:    term = ACC_W'(prod_reg);
            SH_32:   term = ACC_W'(prod_reg) << 32;
            SH_64:   term = ACC_W'(prod_reg) << 64;
            default: term = ACC_W'(prod_reg);
        endcase
        case (cmd.sign_sel)
            SIGN_POS: term_neg = 1'b0;
            SIGN_PC:  term_neg = pc_reg[PC_W-1];
            SIGN_Q:   term_neg = q_neg;
            default:  term_neg = 1'b0;
        endcase
        case (cmd.acc_op)
            ACC_LOAD: acc_next = term_neg ? -term : term;
            ACC_ADD:  acc_next = term_neg ? acc_reg - term : acc_reg + term;
            default:  acc_next = acc_reg;
        endcase
    end

    assign acc_abs = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign prod_sh = prod_reg >> FRAC_BITS;
    assign qrp_pos = signed'({1'b0, prod_sh[QRP_W-2:0]});

    assign init_diff = WIDE_W'(cfg.initial_pressure) - WIDE_W'(qrp_reg);
    assign rep_sum   = WIDE_W'(qrp_reg) + WIDE_W'(pc_reg);

    // Divider: the numerator overflows the state range when it reaches den * 2^QUO_W.
    assign den_sh     = ACC_W'(den_reg) << QUO_W;
    assign trial      = {rem_reg, quo_reg[QUO_W-1]};
    assign trial_ge   = trial >= {1'b0, den_reg};
    assign trial_diff = trial - {1'b0, den_reg};
    assign pc_quo     = signed'({1'b0, quo_reg});

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.div_init)
        begin
            rem_next = acc_reg[QUO_W +: DEN_W];
            quo_next = acc_reg[QUO_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_next = trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], trial_ge};
        end
    end

    always_comb
    begin
        pc_next           = pc_reg;
        prev_time_next    = prev_time_reg;
        started_next      = started_reg;
        res_pressure_next = res_pressure_reg;
        res_held_next     = res_held_reg;
        if (cmd.div_init)
        begin
            prev_time_next = time_reg;
        end
        if (cmd.pc_load)
        begin
            if (ovf_reg)
                pc_next = neg_reg ? PC_W'(PC_MIN_WIDE) : PC_W'(PC_MAX_WIDE);
            else
                pc_next = neg_reg ? -pc_quo : pc_quo;
        end
        case (cmd.res_op)
            RES_INIT:
            begin
                pc_next           = sat_pc(init_diff);
                started_next      = 1'b1;
                prev_time_next    = time_reg;
                res_pressure_next = cfg.initial_pressure;
                res_held_next     = 1'b0;
            end
            RES_HELD:
            begin
                prev_time_next    = time_reg;
                res_pressure_next = sat_out(rep_sum);
                res_held_next     = 1'b1;
            end
            RES_REPORT:
            begin
                res_pressure_next = sat_out(rep_sum);
                res_held_next     = 1'b0;
            end
            default:
            begin
                res_held_next = res_held_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            prev_time_reg <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            prev_time_reg <= prev_time_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            time_reg  <= in_data.sample_time;
            first_reg <= in_data.first_sample;
        end
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        acc_reg  <= acc_next;
        if (cmd.qrp_load)
            qrp_reg <= q_neg ? -qrp_pos : qrp_pos;
        if (cmd.den_load)
        begin
            den_reg <= DEN_W'(prod_reg) + (DEN_W'(dt) << FRAC_BITS);
            mag_reg <= acc_abs[MAG_W-1:0];
            neg_reg <= acc_reg[ACC_W-1];
        end
        if (cmd.div_init)
            ovf_reg <= acc_reg >= den_sh;
        rem_reg          <= rem_next;
        quo_reg          <= quo_next;
        res_pressure_reg <= res_pressure_next;
        res_held_reg     <= res_held_next;
        if (cmd.out_load)
        begin
            out_data_reg.pressure          <= res_pressure_reg;
            out_data_reg.time_not_advanced <= res_held_reg;
        end
    end

    assign status.first_eff = first_reg || !started_reg;
    assign status.advanced  = time_reg > prev_time_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- hw/rtl/wkp_ctrl.sv -----
// ---------------------------------------------------------------------------
// wkp_ctrl
// Sequencer for one sample: flow term, series start or hold, the backward
// Euler numerator and denominator, the serial division and the report.
// ---------------------------------------------------------------------------
module wkp_ctrl
    import wkp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [16:0] {
        ST_IDLE = 17'h00001,
        ST_QRP  = 17'h00002,
        ST_INIT = 17'h00004,
        ST_HOLD = 17'h00008,
        ST_M1   = 17'h00010,
        ST_M2   = 17'h00020,
        ST_M3   = 17'h00040,
        ST_M4   = 17'h00080,
        ST_M5   = 17'h00100,
        ST_M6   = 17'h00200,
        ST_M7   = 17'h00400,
        ST_M8   = 17'h00800,
        ST_DIVI = 17'h01000,
        ST_DIV  = 17'h02000,
        ST_PCL  = 17'h04000,
        ST_REP  = 17'h08000,
        ST_OUT  = 17'h10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.mul_sel = MUL_QRP;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_QRP;
                end
            end
            ST_QRP:
            begin
                cmd.qrp_load = 1'b1;
                cmd.mul_sel  = MUL_PC_LO;
                if (status.first_eff)
                    state_next = ST_INIT;
                else if (!status.advanced)
                    state_next = ST_HOLD;
                else
                    state_next = ST_M1;
            end
            ST_INIT:
            begin
                cmd.res_op = RES_INIT;
                state_next = ST_OUT;
            end
            ST_HOLD:
            begin
                cmd.res_op = RES_HELD;
                state_next = ST_OUT;
            end
            ST_M1:
            begin
                cmd.acc_op    = ACC_LOAD;
                cmd.acc_shift = SH_0;
                cmd.sign_sel  = SIGN_PC;
                cmd.mul_sel   = MUL_PC_HI;
                state_next    = ST_M2;
            end
            ST_M2:
            begin
                cmd.acc_op    = ACC_ADD;
                cmd.acc_shift = SH_32;
                cmd.sign_sel  = SIGN_PC;
                cmd.mul_sel   = MUL_QDT;
                state_next    = ST_M3;
            end
            ST_M3:
            begin
                cmd.acc_op    = ACC_ADD;
                cmd.acc_shift = SH_0;
                cmd.sign_sel  = SIGN_Q;
                cmd.mul_sel   = MUL_RDC;
                state_next    = ST_M4;
            end
            ST_M4:
            begin
                // Denominator from Rd*C plus the time step, and the magnitude of the summed numerator term.
                cmd.den_load = 1'b1;
                state_next   = ST_M5;
            end
            ST_M5:
            begin
                cmd.mul_sel = MUL_M0;
                state_next  = ST_M6;
            end
            ST_M6:
            begin
                cmd.acc_op    = ACC_LOAD;
                cmd.acc_shift = SH_0;
                cmd.mul_sel   = MUL_M1;
                state_next    = ST_M7;
            end
            ST_M7:
            begin
                cmd.acc_op    = ACC_ADD;
                cmd.acc_shift = SH_32;
                cmd.mul_sel   = MUL_M2;
                state_next    = ST_M8;
            end
            ST_M8:
            begin
                cmd.acc_op    = ACC_ADD;
                cmd.acc_shift = SH_64;
                state_next    = ST_DIVI;
            end
            ST_DIVI:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                    state_next = ST_PCL;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_PCL:
            begin
                cmd.pc_load = 1'b1;
                state_next  = ST_REP;
            end
            ST_REP:
            begin
                cmd.res_op = RES_REPORT;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// ----- hw/rtl/windkessel_rcr_pressure_step.sv -----
// ---------------------------------------------------------------------------
// windkessel_rcr_pressure_step
// Three-element windkessel outlet pressure under constant flow, advanced by
// backward Euler in Q16.16 fixed point, one time sample per word.
// ---------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | in_data: sample_time, first_sample
//  out     | out_valid/out_stall| out_data: pressure, time_not_advanced
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// A word that advances time passes through the shared 32x32 multiplier
// and the restoring divider (one quotient bit per cycle, 47 bits) before it
// reaches the output register.
// A series start or a sample with no time step skips the division.
// The next word is accepted once the previous one has moved to the output
// register, even while that word is still stalled.
// Reset loads unit resistances and compliance and clears all model state.
// ---------------------------------------------------------------------------
`include "windkessel_rcr_pressure_step_macros.svh"

module windkessel_rcr_pressure_step
    import wkp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_word_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_word_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    wkp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wkp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    wkp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg       (cfg),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // A finished word never overwrites one that is still waiting downstream.
    `WKP_ASSERT_SAME(a_out_load_free, clk, rst_n, cmd.out_load, status.out_free, "output overwritten while stalled")
    // Only one word is in work at a time.
    `WKP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "accepted a word while busy")
    // The division starts right after its operands are loaded.
    `WKP_ASSERT_NEXT(a_div_follows_init, clk, rst_n, cmd.div_init, cmd.div_step, "divider did not start")

endmodule

// ----- bench/wkp_pressure_checker.sv -----
// ---------------------------------------------------------------------------
// Windkessel pressure step checker
// Watches the sample, result and register ports of the block, predicts each
// outlet pressure word from a private copy of the registers and model state,
// and compares every result word against the oldest prediction in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module wkp_pressure_checker
    import wkp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_word_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_word_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data,
    output int                   fail_count,
    output int                   outstanding
);

    // Wide enough for Rd * (pc * C + dt * Q) with room for the sign.
    localparam int CALC_W = 132;

    cfg_t                   model_cfg;
    logic signed [PC_W-1:0] cap_pressure;
    logic [FIELD_W-1:0]     last_time;
    logic                   series_open;
    out_word_t              pending_pressures[$];

    function automatic logic signed [CALC_W-1:0] clamp_signed(
        input logic signed [CALC_W-1:0] v,
        input int                       bits
    );
        logic signed [CALC_W-1:0] top_lim;
        logic signed [CALC_W-1:0] bottom_lim;
        top_lim    = (CALC_W'(1) << (bits - 1)) - 1;
        bottom_lim = -top_lim - 1;
        if (v > top_lim)
            return top_lim;
        if (v < bottom_lim)
            return bottom_lim;
        return v;
    endfunction

    // Pressure drop across the proximal resistance, truncated toward zero.
    function automatic logic signed [CALC_W-1:0] flow_drop();
        logic [FIELD_W-1:0]       mag;
        logic [2*FIELD_W-1:0]     prod;
        logic signed [CALC_W-1:0] drop;
        mag  = model_cfg.flow_rate[FIELD_W-1] ? -model_cfg.flow_rate : model_cfg.flow_rate;
        prod = (2*FIELD_W)'(mag) * (2*FIELD_W)'(model_cfg.proximal_resistance);
        drop = CALC_W'(prod >> FRAC_BITS);
        return model_cfg.flow_rate[FIELD_W-1] ? -drop : drop;
    endfunction

    function automatic out_word_t step_outlet_pressure(input in_word_t w);
        out_word_t                res;
        logic                     fresh;
        logic [FIELD_W-1:0]       dt;
        logic signed [CALC_W-1:0] p0;
        logic signed [CALC_W-1:0] sum;
        logic signed [CALC_W-1:0] pc_next;
        logic [CALC_W-1:0]        mag;
        logic [CALC_W-1:0]        num;
        logic [CALC_W-1:0]        den;
        logic [CALC_W-1:0]        quo;
        res.time_not_advanced = 1'b0;
        fresh = w.first_sample || !series_open;
        p0    = $signed(model_cfg.initial_pressure);
        if (fresh) begin
            cap_pressure = PC_W'(clamp_signed(p0 - flow_drop(), PC_W));
            series_open  = 1'b1;
        end
        else if (w.sample_time <= last_time) begin
            res.time_not_advanced = 1'b1;
        end
        else begin
            dt  = w.sample_time - last_time;
            sum = cap_pressure * $signed({1'b0, model_cfg.capacitance})
                + $signed(model_cfg.flow_rate) * $signed({1'b0, dt});
            mag = (sum < 0) ? -sum : sum;
            num = mag * CALC_W'(model_cfg.distal_resistance);
            den = CALC_W'(model_cfg.distal_resistance) * CALC_W'(model_cfg.capacitance)
                + (CALC_W'(dt) << FRAC_BITS);
            // Backward Euler update; the single rounding is this truncating divide.
            quo     = num / den;
            pc_next = (sum < 0) ? -$signed(quo) : $signed(quo);
            cap_pressure = PC_W'(clamp_signed(pc_next, PC_W));
        end
        last_time = w.sample_time;
        if (fresh)
            res.pressure = model_cfg.initial_pressure;
        else
            res.pressure = FIELD_W'(clamp_signed(flow_drop() + cap_pressure, OUT_SAT_W));
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t want;
        if (!rst_n) begin
            model_cfg.proximal_resistance = ONE_FIXED;
            model_cfg.capacitance         = ONE_FIXED;
            model_cfg.distal_resistance   = ONE_FIXED;
            model_cfg.flow_rate           = '0;
            model_cfg.initial_pressure    = '0;
            cap_pressure = '0;
            last_time    = '0;
            series_open  = 1'b0;
            fail_count   = 0;
            pending_pressures.delete();
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_PROXIMAL_RESISTANCE: model_cfg.proximal_resistance = cfg_data;
                    REG_CAPACITANCE:         model_cfg.capacitance         = cfg_data;
                    REG_DISTAL_RESISTANCE:   model_cfg.distal_resistance   = cfg_data;
                    REG_FLOW_RATE:           model_cfg.flow_rate           = cfg_data;
                    REG_INITIAL_PRESSURE:    model_cfg.initial_pressure    = cfg_data;
                    default: ;
                endcase
            end
            // Results are matched before new words are queued, so a stray
            // result can never pair with a prediction made in the same cycle.
            if (out_valid && !out_stall) begin
                if (pending_pressures.size() == 0) begin
                    $error("result word with no prediction waiting: pressure %0d",
                           out_data.pressure);
                    fail_count++;
                end
                else begin
                    want = pending_pressures.pop_front();
                    if (out_data.pressure !== want.pressure) begin
                        $error("pressure mismatch: expected %0d, got %0d",
                               want.pressure, out_data.pressure);
                        fail_count++;
                    end
                    if (out_data.time_not_advanced !== want.time_not_advanced) begin
                        $error("time_not_advanced mismatch: expected %0b, got %0b",
                               want.time_not_advanced, out_data.time_not_advanced);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_pressures.insert(pending_pressures.size(),
                                         step_outlet_pressure(in_data));
        end
        outstanding = pending_pressures.size();
    end

endmodule

// ----- bench/testbench.sv -----
// ---------------------------------------------------------------------------
// Windkessel pressure step testbench
// Drives directed and random time-sample series through the block under
// random source gaps and sink stalls, reprograms the RCR registers between
// phases, and reports the checker's verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
    import wkp_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_INITIAL_PRESSURE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

    localparam int RANDOM_WORDS = 1400;
    localparam int PHASES       = 8;
    localparam int DRAIN_CYCLES = 80;
    localparam int TIMEOUT_NS   = 10_000_000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_word_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_word_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]   cfg_data;
    int                   fail_count;
    int                   outstanding;

    bit                   no_idle;
    int                   words_sent;
    logic [FIELD_W-1:0]   t_now;

    windkessel_rcr_pressure_step u_dut (.*);

    wkp_pressure_checker u_checker (.*);

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #TIMEOUT_NS;
        $display("TEST FAILED");
        $finish;
    end

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        int n;
        out_stall = 1'b0;
        @(negedge clk);
        forever begin
            n = pick_gap();
            out_stall <= (n != 0);
            repeat ((n != 0) ? n : $urandom_range(1, 8)) @(negedge clk);
        end
    end

    task automatic send_sample(input logic [FIELD_W-1:0] t, input logic start);
        in_word_t w;
        int       gap;
        w.sample_time  = t;
        w.first_sample = start;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    // Holds the source off until every predicted word has come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_config(
        input logic [FIELD_W-1:0] rp,
        input logic [FIELD_W-1:0] cap,
        input logic [FIELD_W-1:0] rd,
        input logic [FIELD_W-1:0] flow,
        input logic [FIELD_W-1:0] p_init
    );
        settle();
        write_reg(REG_PROXIMAL_RESISTANCE, rp);
        write_reg(REG_CAPACITANCE, cap);
        write_reg(REG_DISTAL_RESISTANCE, rd);
        write_reg(REG_FLOW_RATE, flow);
        write_reg(REG_INITIAL_PRESSURE, p_init);
    endtask

    function automatic logic [FIELD_W-1:0] rand_positive_reg();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        else if (r < 8)
            return 1;
        else if (r < 12)
            return '1;
        else if (r < 25)
            return $urandom;
        return $urandom_range('h100, 'h40000);
    endfunction

    function automatic logic [FIELD_W-1:0] rand_signed_reg();
        int unsigned        r;
        logic [FIELD_W-1:0] m;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 32'h8000_0000;
        else if (r < 8)
            return 32'h7FFF_FFFF;
        else if (r < 12)
            return '0;
        else if (r < 25)
            return $urandom;
        m = $urandom_range(0, 'hC8_0000);
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    // A series start followed mostly by forward steps, with held samples,
    // restarts and a little noise mixed in.
    task automatic run_series(input int length);
        int unsigned        r;
        logic [FIELD_W-1:0] dt;
        t_now = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4096);
        send_sample(t_now, 1'b1);
        repeat (length - 1) begin
            r = $urandom_range(0, 99);
            if (r < 7) begin
                t_now = t_now - (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 'h2_0000));
                send_sample(t_now, 1'b0);
            end
            else if (r < 10) begin
                t_now = $urandom;
                send_sample(t_now, 1'b1);
            end
            else if (r < 13) begin
                t_now = $urandom;
                send_sample(t_now, 1'($urandom_range(0, 1)));
            end
            else begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    dt = $urandom_range(1, 'h4000);
                else if (r < 97)
                    dt = $urandom_range(1, 'hF_FFFF);
                else
                    dt = $urandom;
                t_now = t_now + dt;
                send_sample(t_now, 1'b0);
            end
        end
    endtask

    initial begin
        int phase;
        int target;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_PROXIMAL_RESISTANCE;
        cfg_data   = '0;
        no_idle    = 1'b0;
        words_sent = 0;
        t_now      = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset registers; the first word has no open series to extend.
        send_sample(32'h0000_0100, 1'b0);
        send_sample(32'h0000_0100, 1'b0);
        send_sample(32'h0000_0080, 1'b0);
        send_sample(32'h0001_0080, 1'b0);

        load_config(32'h0000_8000, 32'h0001_8000, 32'h0002_0000, 32'h0005_0000, 32'h0050_0000);
        write_reg(REG_UNUSED_FIRST, '1);
        write_reg(REG_UNUSED_LAST, 32'hDEAD_BEEF);
        send_sample(32'd1000, 1'b1);
        send_sample(32'd1000 + 32'h8000, 1'b0);
        send_sample(32'd1000 + 32'h8001, 1'b0);
        send_sample(32'h0000_0000, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 1'b0);

        // Largest elements with flow and start pressure of opposite sign
        // drive both the capacitor and the outlet pressure into saturation.
        load_config('1, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h0000_0000, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'h0000_0002, 1'b0);

        load_config(32'h0001_0000, 32'h0000_4000, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'h1234_5678, 1'b1);
        send_sample(32'h1235_5678, 1'b0);
        send_sample(32'h1235_5678, 1'b0);

        // Zero resistances and compliance: only dt keeps the divisor positive.
        load_config('0, '0, '0, '1, '1);
        send_sample(32'd5, 1'b1);
        send_sample(32'd6, 1'b0);
        send_sample(32'h8000_0005, 1'b0);
        send_sample(32'h8000_0005, 1'b0);

        load_config(1, 1, 1, 1, 1);
        send_sample(32'h0000_0000, 1'b1);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);

        for (phase = 0; phase < PHASES; phase++) begin
            load_config(rand_positive_reg(), rand_positive_reg(), rand_positive_reg(),
                        rand_signed_reg(), rand_signed_reg());
            no_idle = (phase == 2);
            target  = words_sent + RANDOM_WORDS / PHASES;
            while (words_sent < target) begin
                run_series($urandom_range(4, 40));
                if ($urandom_range(0, 19) == 0)
                    settle();
            end
        end
        no_idle = 1'b0;

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/wkp_pkg.sv
hw/rtl/wkp_cfg_regs.sv
hw/rtl/wkp_datapath.sv
hw/rtl/wkp_ctrl.sv
hw/rtl/windkessel_rcr_pressure_step.sv
bench/wkp_pressure_checker.sv
bench/testbench.sv
